// ===== design/alu8f_pkg.sv =====
// Shared types and operation codes for the 8-bit CPU ALU pipeline.
`timescale 1ns / 1ps

package alu8f_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_ADC   = 4'd1,
        OP_SUB   = 4'd2,
        OP_SBC   = 4'd3,
        OP_AND   = 4'd4,
        OP_XOR   = 4'd5,
        OP_OR    = 4'd6,
        OP_CP    = 4'd7,
        OP_INC8  = 4'd8,
        OP_DEC8  = 4'd9,
        OP_ADD16 = 4'd10,
        OP_INC16 = 4'd11,
        OP_DEC16 = 4'd12,
        OP_SPOFF = 4'd13
    } op_t;

    typedef enum logic [3:0] {
        K_ADD8,
        K_SUB8,
        K_CP,
        K_AND,
        K_LOGIC,
        K_INC8,
        K_DEC8,
        K_ADD16,
        K_KEEP16,
        K_SPOFF,
        K_NOP
    } kind_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] x;
        logic [3:0]  f;
        logic [15:0] opa;
        logic [15:0] opb;
        logic        cin;
        logic [7:0]  logic_res;
    } dec_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] x;
        logic [3:0]  f;
        logic [7:0]  logic_res;
        logic [15:0] sum;
        logic        c4;
        logic        c8;
        logic        c12;
        logic        c16;
    } add_t;

    typedef struct packed {
        logic [15:0] result_value;
        logic        zero_out;
        logic        subtract_out;
        logic        half_carry_out;
        logic        carry_out;
    } res_t;

endpackage

// ===== design/alu8f_decode.sv =====
// Stage 1: operation decode, adder operand selection and logic operations.
`timescale 1ns / 1ps

module alu8f_decode
    import alu8f_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  op,
    input  logic [15:0] first_operand,
    input  logic [15:0] second_operand,
    input  logic [3:0]  flags_in,
    output logic        out_valid,
    input  logic        out_ready,
    output dec_t        out_data
);

    logic valid_reg, valid_next;
    dec_t data_reg, data_next;
    logic [15:0] a16;
    logic [15:0] bz;
    logic [15:0] bn;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign a16 = {8'h00, first_operand[7:0]};
    assign bz  = {8'h00, second_operand[7:0]};
    assign bn  = {8'h00, ~second_operand[7:0]};

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;

        data_next.kind      = K_NOP;
        data_next.x         = first_operand;
        data_next.f         = flags_in;
        data_next.opa       = a16;
        data_next.opb       = 16'h0000;
        data_next.cin       = 1'b0;
        data_next.logic_res = 8'h00;

        unique case (op)
            OP_ADD: begin
                data_next.kind = K_ADD8;
                data_next.opb  = bz;
            end
            OP_ADC: begin
                data_next.kind = K_ADD8;
                data_next.opb  = bz;
                data_next.cin  = flags_in[FLAG_C];
            end
            OP_SUB: begin
                data_next.kind = K_SUB8;
                data_next.opb  = bn;
                data_next.cin  = 1'b1;
            end
            OP_SBC: begin
                data_next.kind = K_SUB8;
                data_next.opb  = bn;
                data_next.cin  = !flags_in[FLAG_C];
            end
            OP_CP: begin
                data_next.kind = K_CP;
                data_next.opb  = bn;
                data_next.cin  = 1'b1;
            end
            OP_AND: begin
                data_next.kind      = K_AND;
                data_next.logic_res = first_operand[7:0] & second_operand[7:0];
            end
            OP_XOR: begin
                data_next.kind      = K_LOGIC;
                data_next.logic_res = first_operand[7:0] ^ second_operand[7:0];
            end
            OP_OR: begin
                data_next.kind      = K_LOGIC;
                data_next.logic_res = first_operand[7:0] | second_operand[7:0];
            end
            OP_INC8: begin
                data_next.kind = K_INC8;
                data_next.cin  = 1'b1;
            end
            OP_DEC8: begin
                // a + 0xFE + 1: nibble carry clear means half borrow
                data_next.kind = K_DEC8;
                data_next.opb  = 16'h00FE;
                data_next.cin  = 1'b1;
            end
            OP_ADD16: begin
                data_next.kind = K_ADD16;
                data_next.opa  = first_operand;
                data_next.opb  = second_operand;
            end
            OP_INC16: begin
                data_next.kind = K_KEEP16;
                data_next.opa  = first_operand;
                data_next.cin  = 1'b1;
            end
            OP_DEC16: begin
                data_next.kind = K_KEEP16;
                data_next.opa  = first_operand;
                data_next.opb  = 16'hFFFF;
            end
            OP_SPOFF: begin
                data_next.kind = K_SPOFF;
                data_next.opa  = first_operand;
                data_next.opb  = {{8{second_operand[7]}}, second_operand[7:0]};
            end
            default: begin
                data_next.kind = K_NOP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/alu8f_adder.sv =====
// Stage 2: shared 16-bit adder with nibble, byte and 12-bit carry taps.
`timescale 1ns / 1ps

module alu8f_adder
    import alu8f_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  dec_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output add_t out_data
);

    logic valid_reg, valid_next;
    add_t data_reg, data_next;
    logic [16:0] sum17;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign sum17 = {1'b0, in_data.opa} + {1'b0, in_data.opb} + {16'h0000, in_data.cin};

    always_comb begin
        valid_next          = in_ready ? in_valid : valid_reg;
        data_next.kind      = in_data.kind;
        data_next.x         = in_data.x;
        data_next.f         = in_data.f;
        data_next.logic_res = in_data.logic_res;
        data_next.sum       = sum17[15:0];
        data_next.c4        = sum17[4] ^ in_data.opa[4] ^ in_data.opb[4];
        data_next.c8        = sum17[8] ^ in_data.opa[8] ^ in_data.opb[8];
        data_next.c12       = sum17[12] ^ in_data.opa[12] ^ in_data.opb[12];
        data_next.c16       = sum17[16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/alu8f_flags.sv =====
// Stage 3: result select, zero detect and flag update; holds the output register.
`timescale 1ns / 1ps

module alu8f_flags
    import alu8f_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  add_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic valid_reg, valid_next;
    res_t data_reg, data_next;
    logic z8;
    logic zl;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign z8 = (in_data.sum[7:0] == 8'h00);
    assign zl = (in_data.logic_res == 8'h00);

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;

        data_next.result_value   = in_data.x;
        data_next.zero_out       = in_data.f[FLAG_Z];
        data_next.subtract_out   = in_data.f[FLAG_N];
        data_next.half_carry_out = in_data.f[FLAG_H];
        data_next.carry_out      = in_data.f[FLAG_C];

        unique case (in_data.kind)
            K_ADD8: begin
                data_next.result_value   = {8'h00, in_data.sum[7:0]};
                data_next.zero_out       = z8;
                data_next.subtract_out   = 1'b0;
                data_next.half_carry_out = in_data.c4;
                data_next.carry_out      = in_data.c8;
            end
            K_SUB8: begin
                data_next.result_value   = {8'h00, in_data.sum[7:0]};
                data_next.zero_out       = z8;
                data_next.subtract_out   = 1'b1;
                data_next.half_carry_out = !in_data.c4;
                data_next.carry_out      = !in_data.c8;
            end
            K_CP: begin
                data_next.zero_out       = z8;
                data_next.subtract_out   = 1'b1;
                data_next.half_carry_out = !in_data.c4;
                data_next.carry_out      = !in_data.c8;
            end
            K_AND: begin
                data_next.result_value   = {8'h00, in_data.logic_res};
                data_next.zero_out       = zl;
                data_next.subtract_out   = 1'b0;
                data_next.half_carry_out = 1'b1;
                data_next.carry_out      = 1'b0;
            end
            K_LOGIC: begin
                data_next.result_value   = {8'h00, in_data.logic_res};
                data_next.zero_out       = zl;
                data_next.subtract_out   = 1'b0;
                data_next.half_carry_out = 1'b0;
                data_next.carry_out      = 1'b0;
            end
            K_INC8: begin
                data_next.result_value   = {8'h00, in_data.sum[7:0]};
                data_next.zero_out       = z8;
                data_next.subtract_out   = 1'b0;
                data_next.half_carry_out = in_data.c4;
            end
            K_DEC8: begin
                data_next.result_value   = {8'h00, in_data.sum[7:0]};
                data_next.zero_out       = z8;
                data_next.subtract_out   = 1'b1;
                data_next.half_carry_out = !in_data.c4;
            end
            K_ADD16: begin
                data_next.result_value   = in_data.sum;
                data_next.subtract_out   = 1'b0;
                data_next.half_carry_out = in_data.c12;
                data_next.carry_out      = in_data.c16;
            end
            K_KEEP16: begin
                data_next.result_value   = in_data.sum;
            end
            K_SPOFF: begin
                data_next.result_value   = in_data.sum;
                data_next.zero_out       = 1'b0;
                data_next.subtract_out   = 1'b0;
                data_next.half_carry_out = in_data.c4;
                data_next.carry_out      = in_data.c8;
            end
            default: begin
                data_next.result_value   = in_data.x;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/eight_bit_cpu_alu_with_flags.sv =====
// Top level of the pipelined 8-bit CPU ALU with flags.
`timescale 1ns / 1ps

// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata; each carries an operation code,
//   two 16-bit operands and the current Z/N/H/C flags. Each word yields exactly one
//   output word on m_tvalid/m_tready/m_tdata with the result and the new flags.
//   Pipeline: decode, 16-bit add, flag/result select. m_tvalid rises once the word has
//   passed through all three registered stages. Throughput is one word per cycle while
//   m_tready stays high; every stage carries its own valid bit and loads whenever it is
//   empty or its successor takes its word.
//   When the receiver holds m_tready low the output word stays put and the stages
//   behind it keep filling; once all three stages are full, s_tready drops. No
//   word is lost or repeated. s_tready depends combinationally on m_tready.
//   Reset (aresetn low, synchronous) empties all stages; m_tvalid is low after
//   reset and s_tready is high.
//   Unused operation codes 14 and 15 pass first_operand and keep the flags.

module eight_bit_cpu_alu_with_flags
    import alu8f_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] op, [19:4] first_operand, [35:20] second_operand, [39:36] flags_in
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] result_value, [16] zero_out, [17] subtract_out, [18] half_carry_out,
    // [19] carry_out, [23:20] zero
    output logic [23:0] m_tdata
);

    logic d_valid, d_ready;
    dec_t d_data;
    logic a_valid, a_ready;
    add_t a_data;
    res_t r_data;

    alu8f_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .op             (s_tdata[3:0]),
        .first_operand  (s_tdata[19:4]),
        .second_operand (s_tdata[35:20]),
        .flags_in       (s_tdata[39:36]),
        .out_valid      (d_valid),
        .out_ready      (d_ready),
        .out_data       (d_data)
    );

    alu8f_adder u_adder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_data   (d_data),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_data  (a_data)
    );

    alu8f_flags u_flags (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_data   (a_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (r_data)
    );

    assign m_tdata = {4'h0, r_data.carry_out, r_data.half_carry_out,
                      r_data.subtract_out, r_data.zero_out, r_data.result_value};

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("pipeline not ready while output drains");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tready && m_tvalid && a_valid && d_valid) |-> !s_tready)
        else $error("input accepted while pipeline full and stalled");

    a_and_half_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid && a_ready && a_data.kind == K_AND) |=> (m_tvalid && m_tdata[18]))
        else $error("and did not set half carry");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule
